// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked on every clock edge, reset included.
`define CHK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/pte_pkg.sv =====
// Package for the palette texture expander: types, constants and helpers.
// No dependencies.
package pte_pkg;
   localparam int MaxSizeLog2Default   = 8;
   localparam int PaletteEntriesDefault = 256;
   localparam logic [31:0] HalfMask    = 32'hfefefeff;
   localparam logic [31:0] AlphaMask   = 32'hff000000;

   localparam logic [2:0] CsrRedShift   = 3'd0;
   localparam logic [2:0] CsrGreenShift = 3'd1;
   localparam logic [2:0] CsrBlueShift  = 3'd2;
   localparam logic [2:0] CsrAlphaPres  = 3'd3;
   localparam logic [2:0] CsrSizeLog2   = 3'd4;
   localparam logic [2:0] CsrMipMode    = 3'd5;

   localparam logic       CmdLoad  = 1'b0;
   localparam logic       CmdPixel = 1'b1;

   localparam logic [1:0] MipNone  = 2'd0;
   localparam logic [1:0] MipFirst = 2'd1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_type;

   typedef struct packed {
      logic [31:0] texel;
      logic [3:0]  level;
      logic [7:0]  column;
      logic [7:0]  row;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [4:0] red_shift;
      logic [4:0] green_shift;
      logic [4:0] blue_shift;
      logic       alpha_present;
      logic [3:0] size_log2;
      logic [1:0] mip_mode;
   } cfg_type;

   // Expanded level-0 texel handed from front to back.
   typedef struct packed {
      logic [31:0] texel;
   } job_type;

   function automatic logic [31:0] halve(input logic [31:0] a, input logic [31:0] b);
      halve = ((a & HalfMask) >> 1) + ((b & HalfMask) >> 1);
   endfunction
endpackage

// ===== rtl/pte_front.sv =====
// Front end: palette store, configuration registers, texel expansion.
// Depends on pte_pkg.
module pte_front #(
   parameter int PALETTE_ENTRIES = pte_pkg::PaletteEntriesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pte_pkg::req_type  req_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output pte_pkg::cfg_type  cfg,
   output logic              job_valid,
   input  logic              job_ready,
   output pte_pkg::job_type  job
);
   localparam int PalBits = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [23:0] palette_mem [PALETTE_ENTRIES];
   pte_pkg::cfg_type cfg_ff, cfg_in;
   // stage 1: palette read pending
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_inrange_ff;
   logic [7:0]  s1_alpha_ff;
   logic [23:0] s1_entry_ff;
   // stage 2: expanded texel
   logic        s2_valid_ff, s2_valid_in;
   logic [31:0] s2_texel_ff;
   logic        pix_acc, inrange, s1_move;
   logic [23:0] entry;
   logic [31:0] packed_v;

   assign inrange   = ({24'd0, req_data.index} < 32'(PALETTE_ENTRIES));
   // stage 1 advances when the stage ahead is free or draining; a request is taken when stage 1 is empty or advancing
   assign s1_move   = !s2_valid_ff || job_ready;
   assign req_ready = !s1_valid_ff || s1_move;
   assign pix_acc   = req_valid && req_ready && (req_data.cmd == pte_pkg::CmdPixel);
   assign csr_ready = 1'b1;

   // palette writes and registered reads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready && req_data.cmd == pte_pkg::CmdLoad && inrange)
         palette_mem[req_data.index[PalBits-1:0]] <= {req_data.red, req_data.green,
                                                     req_data.blue};
      if (pix_acc) begin
         s1_entry_ff   <= palette_mem[req_data.index[PalBits-1:0]];
         s1_inrange_ff <= inrange;
         s1_alpha_ff   <= req_data.alpha;
      end
   end

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pte_pkg::CsrRedShift:   cfg_in.red_shift     = csr_data[4:0];
            pte_pkg::CsrGreenShift: cfg_in.green_shift   = csr_data[4:0];
            pte_pkg::CsrBlueShift:  cfg_in.blue_shift    = csr_data[4:0];
            pte_pkg::CsrAlphaPres:  cfg_in.alpha_present = csr_data[0];
            pte_pkg::CsrSizeLog2:   cfg_in.size_log2     = csr_data[3:0];
            pte_pkg::CsrMipMode:    cfg_in.mip_mode      = csr_data[1:0];
            default: ;
         endcase
      end
   end

   // pack entry with shifts and apply alpha rule
   always_comb begin
      entry    = s1_inrange_ff ? s1_entry_ff : 24'd0;
      packed_v = ({24'd0, entry[23:16]} << cfg_ff.red_shift) |
                 ({24'd0, entry[15:8]}  << cfg_ff.green_shift) |
                 ({24'd0, entry[7:0]}   << cfg_ff.blue_shift);
      if (cfg_ff.alpha_present)
         packed_v = packed_v | {s1_alpha_ff, 24'd0};
      else if (packed_v != 32'd0)
         packed_v = packed_v | pte_pkg::AlphaMask;
   end

   assign s1_valid_in = pix_acc || (s1_valid_ff && !s1_move);
   assign s2_valid_in = (s1_valid_ff && s1_move) || (s2_valid_ff && !job_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '{5'd16, 5'd8, 5'd0, 1'b0, 4'd8, 2'd2};
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_valid_ff && s1_move) s2_texel_ff <= packed_v;
   end

   assign cfg       = cfg_ff;
   assign job_valid = s2_valid_ff;
   assign job.texel = s2_texel_ff;
endmodule

// ===== rtl/pte_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on pte_pkg.
module pte_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  pte_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output pte_pkg::job_type out_job
);
   pte_pkg::job_type slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = slot_ff[rd_ff];

   // hold entries and advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ff] <= in_job;
   end
endmodule

// ===== rtl/pte_back.sv =====
// Back end: walks mip levels, line stores, emits result transfers.
// Depends on pte_pkg.
module pte_back #(
   parameter int MAX_SIZE_LOG2 = pte_pkg::MaxSizeLog2Default
) (
   input  logic             clock,
   input  logic             reset,
   input  pte_pkg::cfg_type cfg,
   input  logic             job_valid,
   output logic             job_ready,
   input  pte_pkg::job_type job,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pte_pkg::rsp_type rsp_data
);
   localparam int Depth   = 2 << MAX_SIZE_LOG2;
   localparam int AddrW   = MAX_SIZE_LOG2 + 1;
   localparam int CntW    = MAX_SIZE_LOG2 + 1;
   localparam int LvlW    = $clog2(MAX_SIZE_LOG2 + 1);
   localparam int Levels  = MAX_SIZE_LOG2 + 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EMIT = 4'b0010,
      ST_READ = 4'b0100,
      ST_AVG  = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [31:0]  v_ff;
   logic [LvlW-1:0] lvl_ff;
   logic [CntW-1:0] col_cnt_ff [Levels];
   logic [CntW-1:0] row_cnt_ff [Levels];
   logic [31:0]  held_ff [Levels];
   logic [31:0]  store_mem [Depth];
   logic [31:0]  rd_a_ff, rd_b_ff;
   logic [AddrW-1:0] addr_ff;
   logic         out_valid_ff, out_valid_in;
   pte_pkg::rsp_type out_ff;

   logic [3:0]  s, top;
   logic [CntW-1:0] dim_mask, col, row;
   logic [AddrW-1:0] base, addr;
   logic        is_top, last_col, out_free;
   logic [31:0] avg;

   // effective size and top level
   always_comb begin
      s = (cfg.size_log2 > 4'(MAX_SIZE_LOG2)) ? 4'(MAX_SIZE_LOG2) : cfg.size_log2;
      if (cfg.mip_mode == pte_pkg::MipNone)       top = 4'd0;
      else if (cfg.mip_mode == pte_pkg::MipFirst) top = (s != 4'd0) ? 4'd1 : 4'd0;
      else                                        top = s;
      dim_mask = CntW'((CntW'(1) << (s - 4'(lvl_ff))) - CntW'(1));
      col      = col_cnt_ff[lvl_ff] & dim_mask;
      row      = row_cnt_ff[lvl_ff] & dim_mask;
      base     = AddrW'(Depth - (Depth >> lvl_ff));
      addr     = base + AddrW'(col);
      is_top   = (4'(lvl_ff) >= top);
      last_col = (col == dim_mask);
      avg = pte_pkg::halve(pte_pkg::halve(held_ff[lvl_ff], v_ff),
                           pte_pkg::halve(rd_a_ff, rd_b_ff));
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign job_ready = (state_ff == ST_IDLE);
   assign out_valid_in = (state_ff == ST_EMIT && out_free) || (out_valid_ff && !rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (job_valid) state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               if (is_top || !row[0] || !col[0]) state_in = ST_IDLE;
               else                              state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_AVG;
         ST_AVG:  state_in = ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequence one level per pass; store, hold or average
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < Levels; i++) begin
            col_cnt_ff[i] <= '0;
            row_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == ST_EMIT && out_free) begin
            if (last_col) begin
               col_cnt_ff[lvl_ff] <= '0;
               row_cnt_ff[lvl_ff] <= (row + CntW'(1)) & dim_mask;
            end else begin
               col_cnt_ff[lvl_ff] <= col + CntW'(1);
               row_cnt_ff[lvl_ff] <= row;
            end
         end
      end
      case (state_ff)
         ST_IDLE: if (job_valid) begin
            v_ff   <= job.texel;
            lvl_ff <= '0;
         end
         ST_EMIT: if (out_free) begin
            out_ff.texel  <= v_ff;
            out_ff.level  <= 4'(lvl_ff);
            out_ff.column <= col[7:0];
            out_ff.row    <= row[7:0];
            out_ff.last   <= is_top || !row[0] || !col[0];
            addr_ff       <= addr;
            if (!is_top && !row[0]) store_mem[addr] <= v_ff;
            if (!is_top && row[0] && !col[0]) held_ff[lvl_ff] <= v_ff;
         end
         ST_READ: begin
            rd_a_ff <= store_mem[addr_ff - AddrW'(1)];
            rd_b_ff <= store_mem[addr_ff];
         end
         ST_AVG: begin
            v_ff   <= avg;
            lvl_ff <= lvl_ff + LvlW'(1);
         end
         default: ;
      endcase
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
endmodule

// ===== rtl/palette_texture_expand_mipmap_unit.sv =====
// Top level of the palette texture expander with 2x2 mip chain.
// Depends on pte_pkg, pte_front, pte_queue, pte_back.
//
// Channels: req_ carries palette loads (cmd 0) and pixels (cmd 1) in raster
// order; rsp_ carries texels with level, column, row and last; csr_ writes
// one configuration register per transfer and is always ready; the user must
// write only while idle, and the block itself does not enforce it. A palette
// load gives no result. A pixel passes two front stages (palette read,
// expansion) and a two-entry queue, then the back sequencer gives its texel.
// The back sequencer takes a job in its idle state and emits its level-0
// texel; for each averaged mip texel it then reads the line store, averages
// and emits, and it takes no new job until the pixel is done.
// The front keeps accepting while the back works, until the queue is full.
// Reset clears the configuration to its defaults, the level counters and
// all valid flags; palette and line stores hold no reset value.
// When the receiver stalls, the result register holds and the back end
// waits, then the queue fills and req_ready drops.
module palette_texture_expand_mipmap_unit #(
   parameter int MAX_SIZE_LOG2   = pte_pkg::MaxSizeLog2Default,
   parameter int PALETTE_ENTRIES = pte_pkg::PaletteEntriesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pte_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pte_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);
   pte_pkg::cfg_type cfg;
   pte_pkg::job_type f_job, b_job;
   logic f_valid, f_ready, b_valid, b_ready;

   pte_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data, .cfg,
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
   );

   pte_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
   );

   pte_back #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_back (
      .clock, .reset, .cfg, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

// ===== rtl/pte_checker.sv =====
// Port-level checker for the palette texture expander, bound to the top.
// Depends on pte_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pte_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pte_pkg::rsp_type rsp_data,
   input logic             csr_ready
);
   `CHK_IMPLY(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result dropped while stalled")
   `CHK_ALWAYS(a_rst_quiet, clock, reset |=> !rsp_valid, "result valid after reset")
   `CHK_IMPLY(a_lvl0_last, clock, reset, rsp_valid && rsp_data.level != 4'd0 && !rsp_data.last |-> rsp_data.column[0] && rsp_data.row[0], "mip continued from incomplete block")
   `CHK_IMPLY(a_csr_ready, clock, reset, csr_ready, "config port not ready")
endmodule

bind palette_texture_expand_mipmap_unit pte_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_data, .csr_ready
);

// ===== sim/palette_texture_expand_mipmap_unit_tb.sv =====
// Testbench for the palette texture expander with 2x2 mip chain.
// Depends on pte_pkg and palette_texture_expand_mipmap_unit;
// self-checking via a local predictor.
module palette_texture_expand_mipmap_unit_tb;

   localparam int WatchdogLimit = 3000;
   localparam int RandomItems   = 220;
   localparam int StoreDepth    = 512;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   pte_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   pte_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Predictor state
   logic [23:0] pal_entry [256];
   bit          pal_written [256];
   int          loaded_ids [$];
   logic [31:0] even_line [StoreDepth];
   logic [31:0] held_texel [8];
   logic [31:0] col_cnt [9];
   logic [31:0] row_cnt [9];
   logic [4:0]  shift_r = 5'd16, shift_g = 5'd8, shift_b = 5'd0;
   logic        opacity_on = 1'b0;
   logic [3:0]  side_log2 = 4'd8;
   logic [1:0]  mip_sel = 2'd2;

   pte_pkg::rsp_type texel_expect_q [$];
   int      fail_count = 0;
   int      items_sent = 0;
   int      texels_seen = 0;
   int      textures_done = 0;
   bit      idle_on = 1'b1;
   int      stall_cycles = 0;

   palette_texture_expand_mipmap_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Masked halving average of two texels
   function automatic logic [31:0] mean_of(input logic [31:0] a, input logic [31:0] b);
      mean_of = ((a & pte_pkg::HalfMask) >> 1) + ((b & pte_pkg::HalfMask) >> 1);
   endfunction

   // Expand one pixel and cascade it through the mip levels
   task automatic expand_and_filter(input pte_pkg::req_type r);
      logic [31:0] v, col, row, dim;
      int s, top, lvl, base;
      pte_pkg::rsp_type x;
      if (r.cmd == pte_pkg::CmdLoad) begin
         pal_entry[r.index] = {r.red, r.green, r.blue};
         if (!pal_written[r.index]) begin
            pal_written[r.index] = 1'b1;
            loaded_ids.push_back(r.index);
         end
         return;
      end
      v = ({24'd0, pal_entry[r.index][23:16]} << shift_r) |
          ({24'd0, pal_entry[r.index][15:8]} << shift_g) |
          ({24'd0, pal_entry[r.index][7:0]} << shift_b);
      if (opacity_on) v = v | {r.alpha, 24'd0};
      else if (v != 0) v = v | pte_pkg::AlphaMask;
      s = (side_log2 > 8) ? 8 : side_log2;
      if (mip_sel == pte_pkg::MipNone) top = 0;
      else if (mip_sel == pte_pkg::MipFirst) top = (s != 0) ? 1 : 0;
      else top = s;
      lvl = 0;
      while (1) begin
         dim = 32'd1 << (s - lvl);
         col = col_cnt[lvl] & (dim - 1);
         row = row_cnt[lvl] & (dim - 1);
         x.texel = v; x.level = lvl[3:0]; x.column = col[7:0];
         x.row = row[7:0]; x.last = 1'b0;
         texel_expect_q.push_back(x);
         if (col + 1 >= dim) begin
            col_cnt[lvl] = 0;
            row_cnt[lvl] = (row + 1) & (dim - 1);
         end else begin
            col_cnt[lvl] = col + 1;
            row_cnt[lvl] = row;
         end
         if (lvl >= top) break;
         base = StoreDepth - (StoreDepth >> lvl);
         if (!row[0]) begin
            even_line[base + col] = v;
            break;
         end
         if (!col[0]) begin
            held_texel[lvl] = v;
            break;
         end
         v = mean_of(mean_of(held_texel[lvl], v),
                     mean_of(even_line[base + col - 1], even_line[base + col]));
         lvl++;
      end
      x = texel_expect_q.pop_back();
      x.last = 1'b1;
      texel_expect_q.push_back(x);
   endtask

   // Send one item; a random gap may precede it
   task automatic send_item(input pte_pkg::req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expand_and_filter(r);
      items_sent++;
   endtask

   // Hold off the sender until every expected texel has arrived
   task automatic drain;
      req_valid <= 1'b0;
      while (texel_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pte_pkg::CsrRedShift:   shift_r    = val[4:0];
         pte_pkg::CsrGreenShift: shift_g    = val[4:0];
         pte_pkg::CsrBlueShift:  shift_b    = val[4:0];
         pte_pkg::CsrAlphaPres:  opacity_on = val[0];
         pte_pkg::CsrSizeLog2:   side_log2  = val[3:0];
         pte_pkg::CsrMipMode:    mip_sel    = val[1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup(input int rs, input int gs, input int bs, input int ap,
                        input int sz, input int mm);
      write_reg(pte_pkg::CsrRedShift, rs);
      write_reg(pte_pkg::CsrGreenShift, gs);
      write_reg(pte_pkg::CsrBlueShift, bs);
      write_reg(pte_pkg::CsrAlphaPres, ap);
      write_reg(pte_pkg::CsrSizeLog2, sz);
      write_reg(pte_pkg::CsrMipMode, mm);
   endtask

   function automatic pte_pkg::req_type load_item(input int idx, input int rgb);
      pte_pkg::req_type r;
      r = '0;
      r.cmd = pte_pkg::CmdLoad; r.index = idx[7:0]; {r.red, r.green, r.blue} = rgb[23:0];
      r.alpha = 8'($urandom);
      return r;
   endfunction

   function automatic pte_pkg::req_type pixel_item(input int idx, input int alpha);
      pte_pkg::req_type r;
      r = '0;
      r.cmd = pte_pkg::CmdPixel; r.index = idx[7:0]; r.alpha = alpha[7:0];
      {r.red, r.green, r.blue} = 24'($urandom);
      return r;
   endfunction

   function automatic pte_pkg::req_type random_pixel;
      return pixel_item(loaded_ids[$urandom_range(0, loaded_ids.size() - 1)], $urandom);
   endfunction

   // Whole texture of random pixels at the current size, with loads mixed in on request
   task automatic run_texture(input bit with_loads, input bit pause_inside);
      int n, side;
      side = 1 << ((side_log2 > 8) ? 8 : side_log2);
      for (n = 0; n < side * side; n++) begin
         if (with_loads && $urandom_range(0, 7) == 0)
            send_item(load_item($urandom_range(0, 255), $urandom));
         if (pause_inside && n == side * side / 2) drain;
         send_item(random_pixel());
      end
      textures_done++;
      drain;
   endtask

   // Zero key, full white, lost high bits, opacity, single texel, all mip modes
   task automatic test_directed;
      send_item(load_item(0, 24'h000000));
      send_item(load_item(255, 24'hffffff));
      send_item(load_item(1, 24'h8001fe));
      drain;
      setup(16, 8, 0, 0, 1, 2);
      send_item(pixel_item(0, 8'h00));
      send_item(pixel_item(255, 8'hff));
      send_item(pixel_item(1, 8'h5a));
      send_item(pixel_item(255, 8'h00));
      drain;
      setup(31, 31, 31, 1, 1, 3);
      send_item(pixel_item(255, 8'h00));
      send_item(pixel_item(1, 8'hff));
      send_item(pixel_item(0, 8'ha5));
      send_item(pixel_item(255, 8'hff));
      drain;
      setup(0, 0, 0, 0, 0, 2);
      send_item(pixel_item(1, 8'h00));
      drain;
      setup(0, 16, 24, 0, 1, 0);
      repeat (4) send_item(random_pixel());
      drain;
      setup(8, 0, 16, 1, 1, 1);
      repeat (4) send_item(random_pixel());
      drain;
   endtask

   // Random textures at small sizes under random settings
   task automatic test_random_textures;
      bit paused;
      paused = 1'b0;
      repeat (40) send_item(load_item($urandom_range(0, 255), $urandom));
      drain;
      while (items_sent < RandomItems) begin
         setup($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
               $urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 3));
         run_texture(1'b1, !paused && side_log2 >= 2);
         if (side_log2 >= 2) paused = 1'b1;
      end
   endtask

   // First half row of the largest texture, then an oversized setting that
   // saturates and finishes the row; no idling
   task automatic test_full_size;
      idle_on = 1'b0;
      setup(16, 8, 0, 0, 8, 3);
      repeat (128) send_item(random_pixel());
      drain;
      setup($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31), 1, 15, 2);
      repeat (128) send_item(random_pixel());
      drain;
   endtask

   // Compare each transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         texels_seen++;
         if (texel_expect_q.size() == 0) begin
            $display("%0t unexpected texel: actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            pte_pkg::rsp_type want;
            want = texel_expect_q.pop_front();
            if (rsp_data.texel !== want.texel || rsp_data.level !== want.level ||
                rsp_data.column !== want.column || rsp_data.row !== want.row ||
                rsp_data.last !== want.last) begin
               $display("%0t mismatch: expected %p actual %p", $time, want, rsp_data);
               fail_count++;
            end
         end
      end
   end

   // Receiver stalls in random bursts
   initial begin
      @(negedge reset);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Watchdog: end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("watchdog expired at %0t", $time);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < 9; i++) begin
         col_cnt[i] = 0;
         row_cnt[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed;
      test_random_textures;
      test_full_size;
      drain;
      $display("covered %0d items, %0d textures, %0d texels checked", items_sent,
               textures_done, texels_seen);
      $display("all mip modes, shift extremes, both alpha rules, sizes 0-3, 8 and 15");
      if (fail_count == 0 && texel_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// ===== palette_texture_expand_mipmap_unit.f =====
+incdir+rtl
rtl/pte_pkg.sv
rtl/pte_front.sv
rtl/pte_queue.sv
rtl/pte_back.sv
rtl/palette_texture_expand_mipmap_unit.sv
rtl/pte_checker.sv
sim/palette_texture_expand_mipmap_unit_tb.sv
